FILE: rtl/laj_pkg.sv
`default_nettype none

package laj_pkg;

   localparam int CostWidth = 32;

   typedef logic [CostWidth-1:0] cost_type;

   typedef enum logic {
      FUNC_START = 1'b0,
      FUNC_JUDGE = 1'b1
   } func_type;

   typedef struct packed {
      func_type func;
      cost_type cost;
   } req_type;

   typedef struct packed {
      logic     accepted;
      cost_type current_cost;
      cost_type best_cost;
      logic     improved;
      logic     stop;
   } rsp_type;

   // Per-cell control: load takes priority over shift.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/laj_cell.sv
`default_nettype none

module laj_cell
   import laj_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  cell_ctl_type  ctl,
   input  cost_type      next_value,
   input  cost_type      load_value,
   output cost_type      value
);

   cost_type value_ff;
   cost_type value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = load_value;
      end else if (ctl.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

FILE: rtl/late_acceptance_judge_core.sv
`default_nettype none

// Late acceptance move judge. The cost history lives in a ring of HISTORY_LEN
// cells that rotates by one slot for every candidate, so cell 0 always holds the
// slot for the current step. A start item goes from acceptance straight to ST_DONE
// and a candidate passes ST_JUDGE first; one that lowers the last slot holding
// the history maximum also passes ST_SCAN, in which the ring makes one full
// turn past the scan unit to find the new maximum and its count. One item is in
// work at a time; a finished result sits in the output register, so the next
// item is taken while it waits for its transfer.
module late_acceptance_judge_core
   import laj_pkg::*;
#(
   parameter int HISTORY_LEN = 8
)(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_data,
   input  wire          csr_wr_en,
   input  wire  [31:0]  csr_wr_data
);

   localparam int CntW = $clog2(HISTORY_LEN + 1);
   localparam int IdxW = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
   localparam logic [CntW-1:0] FullCount = CntW'(HISTORY_LEN);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(HISTORY_LEN - 1);
   localparam logic [31:0] IdleLimitReset = 32'd1000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_JUDGE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type       state_ff;
   req_type         item_ff;
   cost_type        held_ff;
   cost_type        best_ff;
   cost_type        hmax_ff;
   logic [CntW-1:0] cnt_ff;
   logic [31:0]     idle_ff;
   logic [31:0]     limit_ff;
   logic [IdxW-1:0] scan_idx_ff;
   cost_type        scan_max_ff;
   logic [CntW-1:0] scan_cnt_ff;
   logic            accepted_ff;
   logic            improved_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   cost_type        cell_value [HISTORY_LEN];
   cell_ctl_type    cell_ctl [HISTORY_LEN];
   cost_type        load_value;

   logic            req_xfer;
   logic            start_xfer;
   logic            judge_xfer;
   logic            shift_all;
   logic            head_wr;

   cost_type        head;
   logic            acc;
   cost_type        held_in;
   logic            raise;
   logic            lower;
   logic            dec;
   logic [CntW-1:0] cnt_in;
   logic            rescan;
   logic            improve;
   cost_type        scan_max_in;
   logic [CntW-1:0] scan_cnt_in;
   logic            rsp_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign start_xfer = req_xfer && (req_data.func == FUNC_START);
   assign judge_xfer = req_xfer && (req_data.func == FUNC_JUDGE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Judging a candidate against the slot now sitting in cell 0.
   always_comb begin
      head    = cell_value[0];
      acc     = (item_ff.cost == held_ff) || (item_ff.cost < hmax_ff);
      held_in = acc ? item_ff.cost : held_ff;
      raise   = held_in > head;
      lower   = !raise && (held_in < head) && (held_in < held_ff);
      dec     = lower && (head == hmax_ff) && (cnt_ff != '0);
      cnt_in  = dec ? cnt_ff - CntW'(1) : cnt_ff;
      rescan  = lower && (cnt_in == '0);
      improve = held_in < best_ff;
   end

   // Running maximum and count over the value passing cell 0.
   always_comb begin
      scan_max_in = scan_max_ff;
      scan_cnt_in = scan_cnt_ff;
      if ((scan_idx_ff == '0) || (head > scan_max_ff)) begin
         scan_max_in = head;
         scan_cnt_in = CntW'(1);
      end else if (head == scan_max_ff) begin
         scan_cnt_in = scan_cnt_ff + CntW'(1);
      end
   end

   assign shift_all  = judge_xfer || (state_ff == ST_SCAN);
   assign head_wr    = (state_ff == ST_JUDGE) && (raise || lower);
   assign load_value = start_xfer ? req_data.cost : held_in;

   for (genvar i = 0; i < HISTORY_LEN; i++) begin : g_ring
      localparam int NextIdx = (i + 1) % HISTORY_LEN;

      always_comb begin
         cell_ctl[i].shift = shift_all;
         cell_ctl[i].load  = start_xfer || ((i == 0) && head_wr);
      end

      laj_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .next_value (cell_value[NextIdx]),
         .load_value (load_value),
         .value      (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         best_ff      <= '0;
         hmax_ff      <= '0;
         cnt_ff       <= FullCount;
         idle_ff      <= '0;
         limit_ff     <= IdleLimitReset;
         scan_idx_ff  <= '0;
         accepted_ff  <= 1'b0;
         improved_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         // In ST_DONE the output register is refilled instead, below.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  item_ff <= req_data;
               end
               if (start_xfer) begin
                  held_ff     <= req_data.cost;
                  best_ff     <= req_data.cost;
                  hmax_ff     <= req_data.cost;
                  cnt_ff      <= FullCount;
                  idle_ff     <= '0;
                  accepted_ff <= 1'b1;
                  improved_ff <= 1'b0;
                  state_ff    <= ST_DONE;
               end else if (judge_xfer) begin
                  state_ff <= ST_JUDGE;
               end
            end
            ST_JUDGE: begin
               held_ff     <= held_in;
               accepted_ff <= acc;
               cnt_ff      <= cnt_in;
               improved_ff <= improve;
               if (improve) begin
                  best_ff <= held_in;
                  idle_ff <= '0;
               end else if (idle_ff != '1) begin
                  idle_ff <= idle_ff + 32'd1;
               end
               scan_idx_ff <= '0;
               state_ff    <= rescan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
               scan_max_ff <= scan_max_in;
               scan_cnt_ff <= scan_cnt_in;
               scan_idx_ff <= scan_idx_ff + IdxW'(1);
               // After a full turn the ring is back in step alignment.
               if (scan_idx_ff == LastIdx) begin
                  hmax_ff  <= scan_max_in;
                  cnt_ff   <= scan_cnt_in;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{
                     accepted:     accepted_ff,
                     current_cost: held_ff,
                     best_cost:    best_ff,
                     improved:     improved_ff,
                     stop:         (idle_ff >= limit_ff)
                  };
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
